>>> sv/nmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared types, constants and helpers for the multiplexed nixie display core.
// ----------------------------------------------------------------------------
package nmd_pkg;

  localparam int TUBE_COUNT   = 8;
  localparam int ADDRESS_BITS = 4;

  localparam int TUBE_W   = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
  localparam int ANODE_W  = 8;
  localparam int CODE_W   = 4;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 4;
  localparam int MAP_W    = 40;
  localparam int CFG_IDX_W = 1;

  // Binary to BCD conversion: 99999999 fits in 27 bits, eight digits out.
  localparam int BIN_W      = 27;
  localparam int BCD_DIGITS = 8;
  localparam int BCD_W      = BCD_DIGITS * CODE_W;
  localparam int CNT_W      = $clog2(BIN_W + 1);

  localparam logic [BIN_W-1:0]   SAT_MAX    = BIN_W'(99999999);
  localparam logic [CODE_W-1:0]  BLANK_CODE = CODE_W'(10);
  localparam logic [ADDR_W-1:0]  ADDR_MASK  =
    (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((1 << ADDRESS_BITS) - 1);

  localparam logic [MAP_W-1:0]  MAP_RESET     = MAP_W'(64'd654820258320);
  localparam logic [ADDR_W-1:0] INVALID_RESET = ADDR_W'(15);

  localparam logic [CMD_W-1:0] CMD_TICK        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_DIGIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_VALUE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BLANK       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CATHODE_MAP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_ADDR = 1'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic exec_tick;
    logic exec_digit;
    logic exec_blank;
    logic conv_load;
    logic conv_step;
    logic conv_commit;
  } nmd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_done;
  } nmd_stat_t;

  function automatic logic [ADDR_W-1:0] code_to_addr(
    input logic [MAP_W-1:0]  map,
    input logic [ADDR_W-1:0] invalid,
    input logic [CODE_W-1:0] code
  );
    logic [ADDR_W-1:0] addr;
    if (code < CODE_W'(10)) begin
      addr = map[{code, 2'b00} +: ADDR_W];
    end else begin
      addr = invalid;
    end
    return addr & ADDR_MASK;
  endfunction

endpackage

>>> sv/nmd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_ctrl
// Command sequencer: input/output handshake and BCD conversion sequencing.
// ----------------------------------------------------------------------------
module nmd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nmd_pkg::CMD_W-1:0]     in_cmd,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output nmd_pkg::nmd_cmd_t             dp_cmd,
  input  nmd_pkg::nmd_stat_t            dp_stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CONV = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic xfer;
  logic result_set;

  // Result register is free when empty or being drained this cycle
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign xfer      = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    dp_cmd     = '0;
    result_set = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (xfer) begin
          case (in_cmd)
            nmd_pkg::CMD_TICK: begin
              dp_cmd.exec_tick = 1'b1;
              result_set       = 1'b1;
            end
            nmd_pkg::CMD_WRITE_DIGIT: begin
              dp_cmd.exec_digit = 1'b1;
              result_set        = 1'b1;
            end
            nmd_pkg::CMD_WRITE_VALUE: begin
              dp_cmd.conv_load = 1'b1;
              state_nxt        = ST_CONV;
            end
            default: begin
              dp_cmd.exec_blank = 1'b1;
              result_set        = 1'b1;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (dp_stat.conv_done) begin
          dp_cmd.conv_commit = 1'b1;
          result_set         = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          dp_cmd.conv_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_tready) || result_set;
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_value_enters_conv: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && (in_cmd == nmd_pkg::CMD_WRITE_VALUE) |=> state_r == ST_CONV)
    else $error("write value did not start conversion");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> !in_tready)
    else $error("input accepted during conversion");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.conv_commit |=> out_valid_r)
    else $error("conversion commit produced no result");

  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dp_cmd))
    else $error("more than one datapath command in a cycle");
`endif

endmodule

>>> sv/nmd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmd_datapath
// Digit store, scan/pin registers, config registers and double-dabble unit.
// ----------------------------------------------------------------------------
module nmd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nmd_pkg::MAP_W-1:0]         cfg_data,
  input  logic [nmd_pkg::CODE_W-1:0]        in_digit_code,
  input  logic [nmd_pkg::POS_W-1:0]         in_position,
  input  logic [nmd_pkg::VALUE_W-1:0]       in_value,
  input  nmd_pkg::nmd_cmd_t                 dp_cmd,
  output nmd_pkg::nmd_stat_t                dp_stat,
  output logic [nmd_pkg::ANODE_W-1:0]       anode_enable,
  output logic [nmd_pkg::ADDR_W-1:0]        cathode_address
);

  logic [nmd_pkg::MAP_W-1:0]   map_r;
  logic [nmd_pkg::ADDR_W-1:0]  invalid_r;
  logic [nmd_pkg::CODE_W-1:0]  store_r [nmd_pkg::TUBE_COUNT];
  logic [nmd_pkg::TUBE_W-1:0]  scan_r, scan_nxt;
  logic                        active_r;
  logic [nmd_pkg::ADDR_W-1:0]  cathode_r;

  logic [nmd_pkg::BIN_W-1:0]   bin_r;
  logic [nmd_pkg::BCD_W-1:0]   bcd_r;
  logic [nmd_pkg::BCD_W-1:0]   bcd_adj;
  logic [nmd_pkg::CNT_W-1:0]   cnt_r;
  logic [nmd_pkg::BIN_W-1:0]   value_sat;
  logic                        pos_ok;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r     <= nmd_pkg::MAP_RESET;
      invalid_r <= nmd_pkg::INVALID_RESET;
    end else if (cfg_we) begin
      if (cfg_index == nmd_pkg::REG_CATHODE_MAP) begin
        map_r <= cfg_data;
      end
      if (cfg_index == nmd_pkg::REG_INVALID_ADDR) begin
        invalid_r <= cfg_data[nmd_pkg::ADDR_W-1:0];
      end
    end
  end

  // ---------------- scan and pins ----------------
  assign scan_nxt = (scan_r == nmd_pkg::TUBE_W'(nmd_pkg::TUBE_COUNT - 1)) ?
                    '0 : scan_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r    <= '0;
      active_r  <= 1'b0;
      cathode_r <= '0;
    end else if (dp_cmd.exec_tick) begin
      scan_r    <= scan_nxt;
      active_r  <= 1'b1;
      cathode_r <= nmd_pkg::code_to_addr(map_r, invalid_r, store_r[scan_nxt]);
    end
  end

  assign anode_enable    = active_r ? (nmd_pkg::ANODE_W'(1) << scan_r) : '0;
  assign cathode_address = cathode_r;

  // ---------------- digit store ----------------
  assign pos_ok = in_position < nmd_pkg::POS_W'(nmd_pkg::TUBE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nmd_pkg::TUBE_COUNT; i++) begin
        store_r[i] <= '0;
      end
    end else if (dp_cmd.exec_blank) begin
      for (int i = 0; i < nmd_pkg::TUBE_COUNT; i++) begin
        store_r[i] <= nmd_pkg::BLANK_CODE;
      end
    end else if (dp_cmd.conv_commit) begin
      // digits for tubes beyond the tube count are dropped
      for (int i = 0; i < nmd_pkg::TUBE_COUNT; i++) begin
        store_r[i] <= bcd_r[i*nmd_pkg::CODE_W +: nmd_pkg::CODE_W];
      end
    end else if (dp_cmd.exec_digit && pos_ok) begin
      store_r[in_position[nmd_pkg::TUBE_W-1:0]] <= in_digit_code;
    end
  end

  // ---------------- binary to BCD, one bit per cycle ----------------
  assign value_sat = (in_value > nmd_pkg::VALUE_W'(nmd_pkg::SAT_MAX)) ?
                     nmd_pkg::SAT_MAX : in_value[nmd_pkg::BIN_W-1:0];

  always_comb begin
    for (int d = 0; d < nmd_pkg::BCD_DIGITS; d++) begin
      if (bcd_r[d*nmd_pkg::CODE_W +: nmd_pkg::CODE_W] >= nmd_pkg::CODE_W'(5)) begin
        bcd_adj[d*nmd_pkg::CODE_W +: nmd_pkg::CODE_W] =
          bcd_r[d*nmd_pkg::CODE_W +: nmd_pkg::CODE_W] + nmd_pkg::CODE_W'(3);
      end else begin
        bcd_adj[d*nmd_pkg::CODE_W +: nmd_pkg::CODE_W] =
          bcd_r[d*nmd_pkg::CODE_W +: nmd_pkg::CODE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.conv_load) begin
      bin_r <= value_sat;
      bcd_r <= '0;
    end else if (dp_cmd.conv_step) begin
      bcd_r <= {bcd_adj[nmd_pkg::BCD_W-2:0], bin_r[nmd_pkg::BIN_W-1]};
      bin_r <= {bin_r[nmd_pkg::BIN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (dp_cmd.conv_load) begin
      cnt_r <= nmd_pkg::CNT_W'(nmd_pkg::BIN_W);
    end else if (dp_cmd.conv_step && (cnt_r != '0)) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign dp_stat.conv_done = (cnt_r == '0);

endmodule

>>> sv/nixie_multiplex_display_core.sv
`timescale 1ns / 1ps
// Tick, write digit and blank give their result in the cycle after the transfer.
// Write value gives its result once the 27 double-dabble shift steps of the
// binary-to-BCD unit and a commit step have run; no input is taken meanwhile.
// Throughput: one item per cycle for tick, write digit and blank while out_tready is high.
// Reset (rst_n low, synchronous): all codes zero, anodes off, cathode map and invalid
// address back to their defaults.
// ----------------------------------------------------------------------------
// nixie_multiplex_display_core
// Eight-tube multiplexed nixie driver with stream command input and pin result.
// ----------------------------------------------------------------------------
module nixie_multiplex_display_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] cmd, [5:2] digit_code, [9:6] position, [41:10] value, [47:42] zero
  input  logic [47:0]                       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] anode_enable, [11:8] cathode_address, [15:12] zero
  output logic [15:0]                       out_tdata,
  input  logic                              cfg_we,
  input  logic [nmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nmd_pkg::MAP_W-1:0]         cfg_data
);

  nmd_pkg::nmd_cmd_t                  dp_cmd;
  nmd_pkg::nmd_stat_t                 dp_stat;
  logic [nmd_pkg::ANODE_W-1:0]        anode_enable;
  logic [nmd_pkg::ADDR_W-1:0]         cathode_address;

  nmd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tdata[1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  nmd_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_digit_code   (in_tdata[5:2]),
    .in_position     (in_tdata[9:6]),
    .in_value        (in_tdata[41:10]),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .anode_enable    (anode_enable),
    .cathode_address (cathode_address)
  );

  // pins are stable while a result is pending, so they feed the result directly
  assign out_tdata = {4'b0000, cathode_address, anode_enable};

endmodule

>>> tb/sv/nixie_multiplex_display_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nixie_multiplex_display_core_tb
// Sends tick, digit, value and blank commands as stream transfers and tracks
// tube codes, scan position and cathode drive in a scoreboard. Every pin
// transfer is checked against it. The run covers several cathode maps,
// random idling on both channels, a long output stall and an input pause.
// ----------------------------------------------------------------------------
module nixie_multiplex_display_core_tb;
  import nmd_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASE_ITEMS     = 325;
  localparam int unsigned SAT_VALUE = 99999999;

  typedef struct packed {
    logic [ANODE_W-1:0] anodes;
    logic [ADDR_W-1:0]  cathode;
  } pin_drive_t;

  class pin_drive_board;
    logic [MAP_W-1:0]  cathode_map;
    logic [ADDR_W-1:0] invalid_addr;
    logic [CODE_W-1:0] tube_codes [TUBE_COUNT];
    int unsigned       scan_pos;
    bit                lit;
    logic [ADDR_W-1:0] cathode_latch;
    pin_drive_t        expected_pins [$];
    int unsigned       mismatches;
    int unsigned       cmd_seen [4];

    function void clear();
      cathode_map   = MAP_RESET;
      invalid_addr  = INVALID_RESET;
      foreach (tube_codes[i]) tube_codes[i] = '0;
      scan_pos      = 0;
      lit           = 1'b0;
      cathode_latch = '0;
      mismatches    = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] data);
      case (idx)
        REG_CATHODE_MAP:  cathode_map  = data;
        REG_INVALID_ADDR: invalid_addr = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ADDR_W-1:0] cathode_for(logic [CODE_W-1:0] code);
      logic [ADDR_W-1:0] addr;
      if (code < 4'd10) begin
        addr = cathode_map[int'(code) * 4 +: ADDR_W];
      end else begin
        addr = invalid_addr;
      end
      return addr & ADDR_W'((1 << ADDRESS_BITS) - 1);
    endfunction

    // positions past the last tube are dropped
    function void put_code(int unsigned code, int unsigned pos);
      if (pos < TUBE_COUNT) tube_codes[pos] = code[CODE_W-1:0];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] code,
                               logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value);
      int unsigned rest;
      int unsigned div;
      int unsigned d;
      pin_drive_t  pins;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_TICK: begin
          scan_pos      = (scan_pos + 1) % TUBE_COUNT;
          cathode_latch = cathode_for(tube_codes[scan_pos]);
          lit           = 1'b1;
        end
        CMD_WRITE_DIGIT: put_code(code, pos);
        CMD_WRITE_VALUE: begin
          rest = (value > SAT_VALUE) ? SAT_VALUE : value;
          div  = 10000000;
          for (int p = 7; p >= 0; p--) begin
            d    = rest / div;
            rest = rest - d * div;
            put_code(d, p);
            div  = div / 10;
          end
        end
        CMD_BLANK: foreach (tube_codes[i]) tube_codes[i] = BLANK_CODE;
        default: ;
      endcase
      // writes only touch the codes; pins keep the drive of the last tick
      pins.anodes  = lit ? ANODE_W'(1 << scan_pos) : '0;
      pins.cathode = cathode_latch;
      expected_pins.push_back(pins);
    endfunction

    function void check_pins(logic [ANODE_W-1:0] anodes, logic [ADDR_W-1:0] cathode);
      pin_drive_t want;
      if (expected_pins.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pin transfer, expected none, got anodes=%h cathode=%h",
                 $time, anodes, cathode);
        return;
      end
      want = expected_pins.pop_front();
      if (anodes !== want.anodes) begin
        mismatches++;
        $display("%0t: anode_enable mismatch, expected %h, got %h",
                 $time, want.anodes, anodes);
      end
      if (cathode !== want.cathode) begin
        mismatches++;
        $display("%0t: cathode_address mismatch, expected %h, got %h",
                 $time, want.cathode, cathode);
      end
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  // [1:0] cmd, [5:2] digit_code, [9:6] position, [41:10] value, [47:42] zero
  logic [47:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [7:0] anode_enable, [11:8] cathode_address, [15:12] zero
  logic [15:0]          out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [MAP_W-1:0]     cfg_data   = '0;

  pin_drive_board board;
  int  tx_idle_pct   = 0;
  int  rx_idle_pct   = 0;
  bit  hold_off_req  = 1'b0;
  int  settings_used = 1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  nixie_multiplex_display_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // results are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_pins(out_tdata[7:0], out_tdata[11:8]);
      if (in_tvalid && in_tready) begin
        board.note_command(in_tdata[1:0], in_tdata[5:2], in_tdata[9:6], in_tdata[41:10]);
      end
    end
  end

  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end
      out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] code,
                              logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, value, pos, code, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_command();
    int unsigned         pick;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    pos;
    logic [CMD_W-1:0]    cmd;
    pick = $urandom_range(99);
    pos  = ($urandom_range(3) == 0) ? POS_W'($urandom_range(15))
                                    : POS_W'($urandom_range(TUBE_COUNT - 1));
    case ($urandom_range(3))
      0:       value = $urandom_range(SAT_VALUE);
      1:       value = $urandom;
      2:       value = SAT_VALUE - 9 + $urandom_range(20);  // around saturation
      default: value = $urandom_range(9999);
    endcase
    if (pick < 45)      cmd = CMD_TICK;
    else if (pick < 75) cmd = CMD_WRITE_DIGIT;
    else if (pick < 93) cmd = CMD_WRITE_VALUE;
    else                cmd = CMD_BLANK;
    send_command(cmd, CODE_W'($urandom_range(15)), pos, value);
  endtask

  task automatic wait_for_pins();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [MAP_W-1:0] map, logic [ADDR_W-1:0] invalid);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CATHODE_MAP;
    cfg_data  <= map;
    @(posedge clk);
    cfg_index <= REG_INVALID_ADDR;
    cfg_data  <= MAP_W'(invalid);
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_register(REG_CATHODE_MAP, map);
    board.set_register(REG_INVALID_ADDR, MAP_W'(invalid));
    settings_used++;
  endtask

  task automatic run_random_phase(bit with_pressure);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_pressure && n == 100) hold_off_req = 1'b1;
      if (with_pressure && n == 200) wait_for_pins();
      send_random_command();
    end
    wait_for_pins();
  endtask

  initial begin : stimulus
    logic [MAP_W-1:0] shuffled_map;
    board = new;
    board.clear();
    tx_idle_pct = 6;
    rx_idle_pct = 65;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pins stay dark until the first tick, which lights tube 1
    send_command(CMD_WRITE_DIGIT, 4'd9, 4'd0, 32'h0);
    send_command(CMD_TICK, 4'd0, 4'd0, 32'h0);
    send_command(CMD_WRITE_DIGIT, 4'd15, 4'd7, 32'hFFFF_FFFF);
    send_command(CMD_WRITE_DIGIT, 4'd10, 4'd3, 32'h0);
    send_command(CMD_WRITE_DIGIT, 4'd5, 4'd8, 32'h0);    // off the end, ignored
    send_command(CMD_WRITE_DIGIT, 4'd0, 4'd15, 32'h0);
    send_command(CMD_TICK, 4'd15, 4'd15, 32'h0);
    send_command(CMD_TICK, 4'd0, 4'd0, 32'h0);
    send_command(CMD_WRITE_VALUE, 4'd0, 4'd0, 32'd12345678);
    repeat (3) send_command(CMD_TICK, 4'd0, 4'd0, 32'h0);
    send_command(CMD_WRITE_VALUE, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_command(CMD_TICK, 4'd0, 4'd0, 32'h0);
    send_command(CMD_WRITE_VALUE, 4'd0, 4'd0, 32'd0);
    send_command(CMD_WRITE_VALUE, 4'd0, 4'd0, 32'd99999999);
    send_command(CMD_WRITE_VALUE, 4'd0, 4'd0, 32'd100000000);
    send_command(CMD_TICK, 4'd0, 4'd0, 32'h0);
    send_command(CMD_BLANK, 4'd0, 4'd0, 32'h0);
    repeat (2) send_command(CMD_TICK, 4'd0, 4'd0, 32'h0);

    run_random_phase(1'b1);

    apply_settings('0, '0);
    tx_idle_pct = 65;
    rx_idle_pct = 6;
    run_random_phase(1'b0);

    apply_settings('1, 4'hF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(1'b0);

    shuffled_map = {8'($urandom), 32'($urandom)};
    apply_settings(shuffled_map, ADDR_W'($urandom_range(15)));
    run_random_phase(1'b0);

    $display("Checked %0d ticks, %0d digit writes, %0d value writes and %0d blanks",
             board.cmd_seen[CMD_TICK], board.cmd_seen[CMD_WRITE_DIGIT],
             board.cmd_seen[CMD_WRITE_VALUE], board.cmd_seen[CMD_BLANK]);
    $display("across %0d cathode map settings, with output stalls and input pauses",
             settings_used);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
